// ----- rtl/slcan_pkg.sv -----
// shared types and constants of the slcan ascii frame parser
// used by slcan_parser_core and slcan_ascii_frame_parser_unit; no dependencies
`default_nettype none

package slcan_pkg;

    // line format limits
    localparam int MAX_DATA_BYTES = 8;
    localparam int MAX_LINE_CHARS = 100;

    localparam int POS_W   = 7;
    localparam int ID_W    = 29;
    localparam int DLC_W   = 4;
    localparam int DATA_W  = 64;
    localparam int TS_W    = 16;
    localparam int LEN_W   = 7;

    localparam logic [POS_W-1:0] LINE_MAX = POS_W'(MAX_LINE_CHARS);
    localparam logic [DLC_W-1:0] DLC_MAX  = DLC_W'(MAX_DATA_BYTES);

    // control characters
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_BEL = 8'h07;

    // frame opening characters
    localparam logic [7:0] CH_LT  = "t";
    localparam logic [7:0] CH_UT  = "T";
    localparam logic [7:0] CH_LR  = "r";
    localparam logic [7:0] CH_UR  = "R";

    // result kinds
    localparam logic ITEM_FRAME = 1'b0;
    localparam logic ITEM_REPLY = 1'b1;

    // packed output payload widths
    localparam int RES_BITS  = 2 + ID_W + DLC_W + DATA_W + TS_W + 1 + 1 + 8 + LEN_W;
    localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD = TDATA_W - RES_BITS;

    typedef struct packed {
        logic               item_kind;
        logic               is_extended;
        logic               is_remote;
        logic [ID_W-1:0]    frame_id;
        logic [DLC_W-1:0]   frame_dlc;
        logic [DATA_W-1:0]  frame_data;
        logic [TS_W-1:0]    frame_timestamp;
        logic               format_error;
        logic               reply_ended_by_bell;
        logic [7:0]         reply_first_char;
        logic [LEN_W-1:0]   reply_length;
    } slcan_result_t;

endpackage

`default_nettype wire

// ----- rtl/slcan_parser_core.sv -----
// per-character line parser: holds the line state and forms the result of one byte
// depends on slcan_pkg
`default_nettype none

module slcan_parser_core
    import slcan_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step_en,
    input  wire logic [7:0]    rx_byte,
    output logic               res_valid,
    output slcan_result_t      res
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FRAME,
        MODE_REPLY
    } mode_t;

    mode_t                mode_reg,  mode_next;
    logic [POS_W-1:0]     pos_reg,   pos_next;
    logic                 ext_reg,   ext_next;
    logic                 rem_reg,   rem_next;
    logic [ID_W-1:0]      id_reg,    id_next;
    logic [DLC_W-1:0]     dlc_reg,   dlc_next;
    logic [DATA_W-1:0]    data_reg,  data_next;
    logic [TS_W-1:0]      ts_reg,    ts_next;
    logic                 err_reg,   err_next;
    logic [7:0]           first_reg, first_next;

    logic [4:0]           hex;
    logic                 hex_ok;
    logic [3:0]           nib;
    logic                 is_dec;
    logic [POS_W-1:0]     id_end;
    logic [POS_W-1:0]     dlc_pos;
    logic [POS_W-1:0]     d0;
    logic [POS_W-1:0]     t0;
    logic [POS_W-1:0]     ts_end;
    logic [POS_W-1:0]     off;
    logic [3:0]           nib_idx;
    logic [POS_W-1:0]     pos_inc;
    logic [ID_W-1:0]      id_shift;
    logic                 end_err;
    logic                 is_term;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign hex     = hex_decode(rx_byte);
    assign hex_ok  = hex[4];
    assign nib     = hex[3:0];
    assign is_dec  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign is_term = (rx_byte == CH_CR) || (rx_byte == CH_BEL);

    assign id_end  = ext_reg ? POS_W'(8) : POS_W'(3);
    assign dlc_pos = id_end + POS_W'(1);
    assign d0      = id_end + POS_W'(2);
    assign t0      = d0 + (rem_reg ? POS_W'(0) : POS_W'({dlc_reg, 1'b0}));
    assign ts_end  = t0 + POS_W'(4);
    assign off     = pos_reg - d0;
    assign nib_idx = {off[3:1], ~off[0]};
    assign pos_inc = (pos_reg < LINE_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign id_shift = {id_reg[ID_W-5:0], nib};

    assign end_err = err_reg || (pos_reg <= dlc_pos) ||
                     ((pos_reg != t0) && (pos_reg != ts_end));

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ext_next   = ext_reg;
        rem_next   = rem_reg;
        id_next    = id_reg;
        dlc_next   = dlc_reg;
        data_next  = data_reg;
        ts_next    = ts_reg;
        err_next   = err_reg;
        first_next = first_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (mode_reg)
            MODE_FRAME:
            begin
                if (rx_byte == CH_CR)
                begin
                    res_valid           = 1'b1;
                    res.item_kind       = ITEM_FRAME;
                    res.is_extended     = ext_reg;
                    res.is_remote       = rem_reg;
                    res.frame_id        = id_reg;
                    res.frame_dlc       = dlc_reg;
                    res.frame_data      = data_reg;
                    res.frame_timestamp = ts_reg;
                    res.format_error    = end_err;
                    err_next            = end_err;
                    mode_next           = MODE_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (pos_reg <= id_end)
                    begin
                        // identifier digit, overflow checked per form
                        id_next = id_shift;
                        if (!hex_ok || (ext_reg && id_reg[ID_W-1:ID_W-4] != 4'd0) ||
                            (!ext_reg && id_shift[ID_W-1:11] != '0))
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (pos_reg == dlc_pos)
                    begin
                        if (is_dec)
                        begin
                            if (rx_byte[3:0] > DLC_MAX)
                            begin
                                dlc_next = DLC_MAX;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                dlc_next = rx_byte[3:0];
                            end
                        end
                        else
                        begin
                            dlc_next = '0;
                            err_next = 1'b1;
                        end
                    end
                    else if (pos_reg < t0)
                    begin
                        // high nibble first within each data byte
                        for (int k = 0; k < DATA_W / 4; k++)
                        begin
                            if (nib_idx == 4'(k))
                            begin
                                data_next[4*k +: 4] = data_reg[4*k +: 4] | nib;
                            end
                        end
                        if (!hex_ok)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (pos_reg < ts_end)
                    begin
                        ts_next = {ts_reg[TS_W-5:0], nib};
                        if (!hex_ok)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end

            MODE_REPLY:
            begin
                pos_next = pos_inc;
                if (is_term)
                begin
                    res_valid               = 1'b1;
                    res.item_kind           = ITEM_REPLY;
                    res.reply_ended_by_bell = (rx_byte == CH_BEL);
                    res.reply_first_char    = first_reg;
                    res.reply_length        = LEN_W'(pos_inc);
                    mode_next               = MODE_IDLE;
                end
            end

            MODE_IDLE:
            begin
                // first character of a new line
                id_next   = '0;
                dlc_next  = '0;
                data_next = '0;
                ts_next   = '0;
                err_next  = 1'b0;
                pos_next  = POS_W'(1);
                if (rx_byte == CH_LT || rx_byte == CH_UT || rx_byte == CH_LR ||
                    rx_byte == CH_UR)
                begin
                    ext_next  = (rx_byte == CH_UT) || (rx_byte == CH_UR);
                    rem_next  = (rx_byte == CH_LR) || (rx_byte == CH_UR);
                    mode_next = MODE_FRAME;
                end
                else
                begin
                    ext_next   = 1'b0;
                    rem_next   = 1'b0;
                    first_next = rx_byte;
                    if (is_term)
                    begin
                        res_valid               = 1'b1;
                        res.item_kind           = ITEM_REPLY;
                        res.reply_ended_by_bell = (rx_byte == CH_BEL);
                        res.reply_first_char    = rx_byte;
                        res.reply_length        = LEN_W'(1);
                        mode_next               = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = MODE_REPLY;
                    end
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
        end
        else if (step_en)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            ext_reg   <= ext_next;
            rem_reg   <= rem_next;
            id_reg    <= id_next;
            dlc_reg   <= dlc_next;
            data_reg  <= data_next;
            ts_reg    <= ts_next;
            err_reg   <= err_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/slcan_ascii_frame_parser_unit.sv -----
// top level of the slcan ascii frame parser: stream ports, input and result registers
// depends on slcan_pkg and slcan_parser_core
`default_nettype none

// Parses the ascii receive stream of a serial can adapter, one character per
// transaction on s_axis. A line that opens with t, T, r or R is a can frame
// (3 or 8 hex id digits, a dlc digit, 2*dlc hex data digits unless remote, an
// optional 4-digit hex timestamp, then cr); the cr yields one frame result with
// tuser 0. Any other first character opens a reply line ending at cr or bel,
// which yields one reply result with tuser 1 carrying its first character and
// its length (saturating at 100). Malformed frames are reported with
// format_error set and the partial values kept. Throughput is one character
// per clock unless a line end waits; a character is held in the input
// register and its result in the result register on m_axis. A character
// only waits when it ends a line and the result register holds a result not
// yet taken; others flow on while m_axis stalls. No clearing pass after reset.
module slcan_ascii_frame_parser_unit
    import slcan_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // rx_byte[7:0]
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [TDATA_W-1:0]       m_axis_tdata,   // is_extended, is_remote, frame_id,
                                                     // frame_dlc, frame_data,
                                                     // frame_timestamp, format_error,
                                                     // reply_ended_by_bell,
                                                     // reply_first_char, reply_length,
                                                     // zero pad
    output logic                     m_axis_tuser    // item_kind
);

    // input register
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;

    // result register
    logic                 out_valid_reg;
    slcan_result_t        out_reg;

    logic                 res_valid;
    slcan_result_t        res;
    logic                 out_free;
    logic                 advance;

    // the held character moves on unless it makes a result with no room for it
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!res_valid || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    slcan_parser_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.item_kind;
    assign m_axis_tdata  = {
        {TDATA_PAD{1'b0}},
        out_reg.reply_length,
        out_reg.reply_first_char,
        out_reg.reply_ended_by_bell,
        out_reg.format_error,
        out_reg.frame_timestamp,
        out_reg.frame_data,
        out_reg.frame_dlc,
        out_reg.frame_id,
        out_reg.is_remote,
        out_reg.is_extended
    };

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench of slcan_ascii_frame_parser_unit: directed lines, then random traffic
// depends on slcan_pkg and the parser rtl; results checked against an in-bench line parser
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcan_pkg::*;

    // bit offsets of the result fields in m_axis_tdata, lowest first
    localparam int OFS_EXT   = 0;
    localparam int OFS_REM   = 1;
    localparam int OFS_ID    = 2;
    localparam int OFS_DLC   = OFS_ID + ID_W;
    localparam int OFS_DATA  = OFS_DLC + DLC_W;
    localparam int OFS_TS    = OFS_DATA + DATA_W;
    localparam int OFS_ERR   = OFS_TS + TS_W;
    localparam int OFS_BELL  = OFS_ERR + 1;
    localparam int OFS_FIRST = OFS_BELL + 1;
    localparam int OFS_LEN   = OFS_FIRST + 8;
    localparam int PAYLOAD_W = OFS_LEN + LEN_W;

    localparam logic [ID_W-1:0] STD_ID_MAX = ID_W'(11'h7ff);

    // ascii characters the parser cares about
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_UA   = "A";
    localparam logic [7:0] CH_UF   = "F";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_LF   = "f";

    localparam int RANDOM_CHARS = 1400;
    localparam int HOLD_AT      = 30;   // result count at which the sink stalls
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {LINE_IDLE, LINE_FRAME, LINE_REPLY} line_mode_t;

    typedef struct {
        string         text;
        bit            typed;   // want holds the result of the closing character
        slcan_result_t want;
    } line_case_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tuser;

    slcan_result_t pending_results[$];
    line_case_t    directed_cases[$];
    logic [7:0]    line_q[$];
    int            chars_sent = 0;
    int            mismatches = 0;

    // line parser state, mirrors the block after reset
    line_mode_t         line_mode = LINE_IDLE;
    logic [POS_W-1:0]   pos_cnt = '0;
    logic               ext_q = 1'b0;
    logic               rem_q = 1'b0;
    logic [ID_W-1:0]    id_acc = '0;
    logic [DLC_W-1:0]   dlc_q = '0;
    logic [DATA_W-1:0]  data_acc = '0;
    logic [TS_W-1:0]    ts_acc = '0;
    logic               err_q = 1'b0;
    logic [7:0]         first_q = 8'h00;

    slcan_ascii_frame_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic slcan_result_t frame_result(input logic ext, input logic rem,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [DLC_W-1:0] dlc,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic [TS_W-1:0] ts,
                                                   input logic err);
        slcan_result_t r;
        r = '0;
        r.item_kind       = ITEM_FRAME;
        r.is_extended     = ext;
        r.is_remote       = rem;
        r.frame_id        = id;
        r.frame_dlc       = dlc;
        r.frame_data      = data;
        r.frame_timestamp = ts;
        r.format_error    = err;
        return r;
    endfunction

    function automatic slcan_result_t reply_result(input logic bell, input logic [7:0] first,
                                                   input logic [LEN_W-1:0] len);
        slcan_result_t r;
        r = '0;
        r.item_kind           = ITEM_REPLY;
        r.reply_ended_by_bell = bell;
        r.reply_first_char    = first;
        r.reply_length        = len;
        return r;
    endfunction

    // non-hex characters flag the frame and count as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return c[3:0];
        if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF))
            return c[3:0] + 4'd9;
        err_q = 1'b1;
        return 4'd0;
    endfunction

    function automatic void bump_pos();
        if (pos_cnt < LINE_MAX)
            pos_cnt = pos_cnt + 1'b1;
    endfunction

    // advance the line parser by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, output slcan_result_t res);
        int idlen;
        int t0;
        int off;
        int p;
        logic [3:0] nib;
        res = '0;
        idlen = ext_q ? 8 : 3;
        t0 = idlen + 2 + (rem_q ? 0 : 2 * int'(dlc_q));
        p = int'(pos_cnt);
        case (line_mode)
            LINE_FRAME:
            begin
                if (c == CH_CR)
                begin
                    // short frame, cut-off data or timestamp digits, or trailing characters
                    if (p <= idlen + 1 || (p != t0 && p != t0 + 4))
                        err_q = 1'b1;
                    line_mode = LINE_IDLE;
                    res = frame_result(ext_q, rem_q, id_acc, dlc_q, data_acc, ts_acc, err_q);
                    return 1'b1;
                end
                if (p <= idlen)
                begin
                    nib = hex_nibble(c);
                    if (ext_q && id_acc[ID_W-1:ID_W-4] != 4'd0)
                        err_q = 1'b1;
                    id_acc = {id_acc[ID_W-5:0], nib};
                    if (!ext_q && id_acc > STD_ID_MAX)
                        err_q = 1'b1;
                end
                else if (p == idlen + 1)
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        if (c[3:0] > DLC_MAX)
                        begin
                            dlc_q = DLC_MAX;
                            err_q = 1'b1;
                        end
                        else
                            dlc_q = c[3:0];
                    end
                    else
                    begin
                        dlc_q = '0;
                        err_q = 1'b1;
                    end
                end
                else if (p < t0)
                begin
                    // high nibble of each data byte comes first
                    off = p - (idlen + 2);
                    nib = hex_nibble(c);
                    data_acc |= DATA_W'(nib) << (8 * ((off >> 1) & 7) + ((off & 1) ? 0 : 4));
                end
                else if (p < t0 + 4)
                    ts_acc = {ts_acc[TS_W-5:0], hex_nibble(c)};
                else
                    err_q = 1'b1;   // trailing junk after the timestamp
                bump_pos();
                return 1'b0;
            end
            LINE_REPLY:
            begin
                bump_pos();
                if (c == CH_CR || c == CH_BEL)
                begin
                    line_mode = LINE_IDLE;
                    res = reply_result(c == CH_BEL, first_q, pos_cnt);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
            begin
                // first character of a new line
                id_acc   = '0;
                dlc_q    = '0;
                data_acc = '0;
                ts_acc   = '0;
                err_q    = 1'b0;
                pos_cnt  = POS_W'(1);
                if (c == CH_LT || c == CH_UT || c == CH_LR || c == CH_UR)
                begin
                    ext_q = (c == CH_UT || c == CH_UR);
                    rem_q = (c == CH_LR || c == CH_UR);
                    line_mode = LINE_FRAME;
                    return 1'b0;
                end
                ext_q = 1'b0;
                rem_q = 1'b0;
                first_q = c;
                if (c == CH_CR || c == CH_BEL)
                begin
                    // a bare terminator is a reply of length one
                    res = reply_result(c == CH_BEL, c, LEN_W'(1));
                    return 1'b1;
                end
                line_mode = LINE_REPLY;
                return 1'b0;
            end
        endcase
    endfunction

    // idle gap before a transaction, with stretches of back-to-back traffic
    function automatic int draw_gap(input int n);
        if ((n / 60) % 4 == 3)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // append a value as hex digits, most significant first, in random letter case
    function automatic void push_hex(input logic [31:0] v, input int digits);
        logic [3:0] n;
        for (int i = digits - 1; i >= 0; i--)
        begin
            n = v[4*i +: 4];
            if (n < 4'd10)
                line_q.push_back(CH_ZERO + 8'(n));
            else
                line_q.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n - 4'd10));
        end
    endfunction

    function automatic void add_case(input string text, input bit typed,
                                     input slcan_result_t want);
        line_case_t lc;
        lc.text  = text;
        lc.typed = typed;
        lc.want  = want;
        directed_cases.push_back(lc);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // one character transaction on s_axis; the parser advances when it is taken
    task automatic send_char(input logic [7:0] c, input bit typed, input slcan_result_t want);
        slcan_result_t res;
        int gap;
        gap = draw_gap(chars_sent);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        chars_sent++;
        if (parse_char(c, res))
            pending_results.push_back(typed ? want : res);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // stimulus
    initial
    begin : char_source
        int pick;
        int cut;
        int body;
        bit ext;
        bit rem;
        logic [31:0] idv;
        int dlc;
        logic [7:0] b;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // bare terminators, extremes and malformed-frame cases
        add_case("\x0d", 1'b1, reply_result(1'b0, CH_CR, LEN_W'(1)));
        add_case("\x07", 1'b1, reply_result(1'b1, CH_BEL, LEN_W'(1)));
        add_case("t0000\x0d", 1'b1, frame_result(0, 0, '0, '0, '0, '0, 0));
        add_case("t7FF8FFFFFFFFFFFFFFFF\x0d", 1'b1,
                 frame_result(0, 0, ID_W'(32'h7ff), DLC_MAX, '1, '0, 0));
        add_case("T1FFFFFFF8ffffffffffffffffFFFF\x0d", 1'b1,
                 frame_result(1, 0, '1, DLC_MAX, '1, '1, 0));
        add_case("t8000\x0d", 1'b1, frame_result(0, 0, ID_W'(32'h800), '0, '0, '0, 1));
        add_case("T200000000\x0d", 1'b1, frame_result(1, 0, '0, '0, '0, '0, 1));
        add_case("t\x0d", 1'b1, frame_result(0, 0, '0, '0, '0, '0, 1));
        add_case("z\x07", 1'b1, reply_result(1'b1, "z", LEN_W'(2)));
        add_case("\xff\x0d", 1'b1, reply_result(1'b0, 8'hff, LEN_W'(2)));
        add_case("r1230\x0d", 1'b0, '0);
        add_case("R1abcdef08\x0d", 1'b0, '0);
        add_case("t12390\x0d", 1'b0, '0);
        add_case("t123x\x0d", 1'b0, '0);
        add_case("t1232Ab\x0d", 1'b0, '0);
        add_case("t1231ab12\x0d", 1'b0, '0);
        add_case("t1231ab1234zz\x0d", 1'b0, '0);
        add_case("t1g31ab\x0d", 1'b0, '0);
        add_case("t12\x071\x0d", 1'b0, '0);
        add_case("t2a12bCD1a2B\x0d", 1'b0, '0);
        add_case("V1013\x0d", 1'b0, '0);

        foreach (directed_cases[k])
            for (int i = 0; i < directed_cases[k].text.len(); i++)
                send_char(directed_cases[k].text[i],
                          directed_cases[k].typed && i == directed_cases[k].text.len() - 1,
                          directed_cases[k].want);

        // random lines: mostly clean frames, some damaged, replies and raw noise
        while (chars_sent < RANDOM_CHARS)
        begin
            line_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                ext = $urandom_range(0, 1);
                rem = $urandom_range(0, 1);
                line_q.push_back(ext ? (rem ? CH_UR : CH_UT) : (rem ? CH_LR : CH_LT));
                if (ext)
                begin
                    idv = $urandom;
                    if ($urandom_range(0, 9) != 0)
                        idv[31:29] = 3'b000;
                    push_hex(idv, 8);
                end
                else
                begin
                    idv = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 'h7ff)
                                                      : $urandom_range(0, 'hfff);
                    push_hex(idv, 3);
                end
                dlc = $urandom_range(0, 8);
                push_hex(dlc, 1);
                if (!rem)
                    repeat (dlc) push_hex($urandom_range(0, 255), 2);
                if ($urandom_range(0, 1))
                    push_hex($urandom_range(0, 'hffff), 4);
                if (pick >= 55)
                begin
                    cut = $urandom_range(1, line_q.size() - 1);
                    case ($urandom_range(0, 4))
                        0: line_q[cut] = 8'($urandom_range(0, 255));
                        1: line_q = line_q[0:cut-1];
                        2: repeat ($urandom_range(1, 6)) push_hex($urandom_range(0, 15), 1);
                        3: line_q[ext ? 9 : 4] = CH_NINE;
                        default:
                            // long enough to saturate the position counter
                            repeat ($urandom_range(90, 120))
                                line_q.push_back(8'($urandom_range(32, 126)));
                    endcase
                end
                line_q.push_back(CH_CR);
            end
            else if (pick < 90)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_LT || b == CH_UT || b == CH_LR || b == CH_UR);
                line_q.push_back(b);
                if (b != CH_CR && b != CH_BEL)
                begin
                    body = ($urandom_range(0, 19) == 0) ? $urandom_range(95, 130)
                                                        : $urandom_range(0, 15);
                    repeat (body)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_CR || b == CH_BEL);
                        line_q.push_back(b);
                    end
                    line_q.push_back($urandom_range(0, 1) ? CH_BEL : CH_CR);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
                line_q.push_back(CH_CR);
            end
            foreach (line_q[i])
                send_char(line_q[i], 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result sink with random stalls and one long hold-off
    initial
    begin : result_sink
        int taken;
        int gap;
        slcan_result_t got;
        slcan_result_t want;
        logic [TDATA_W-1:0] d;

        taken = 0;
        @(posedge rst_n);
        forever
        begin
            // the long hold lets the block fill up and push back on s_axis
            gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(taken);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
            d = m_axis_tdata;
            got = '0;
            got.item_kind           = m_axis_tuser;
            got.is_extended         = d[OFS_EXT];
            got.is_remote           = d[OFS_REM];
            got.frame_id            = d[OFS_ID +: ID_W];
            got.frame_dlc           = d[OFS_DLC +: DLC_W];
            got.frame_data          = d[OFS_DATA +: DATA_W];
            got.frame_timestamp     = d[OFS_TS +: TS_W];
            got.format_error        = d[OFS_ERR];
            got.reply_ended_by_bell = d[OFS_BELL];
            got.reply_first_char    = d[OFS_FIRST +: 8];
            got.reply_length        = d[OFS_LEN +: LEN_W];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual tuser %0b tdata %h",
                         $time, m_axis_tuser, d);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("item_kind", want.item_kind, got.item_kind);
                check_field("is_extended", want.is_extended, got.is_extended);
                check_field("is_remote", want.is_remote, got.is_remote);
                check_field("frame_id", want.frame_id, got.frame_id);
                check_field("frame_dlc", want.frame_dlc, got.frame_dlc);
                check_field("frame_data", want.frame_data, got.frame_data);
                check_field("frame_timestamp", want.frame_timestamp, got.frame_timestamp);
                check_field("format_error", want.format_error, got.format_error);
                check_field("reply_ended_by_bell", want.reply_ended_by_bell,
                            got.reply_ended_by_bell);
                check_field("reply_first_char", want.reply_first_char, got.reply_first_char);
                check_field("reply_length", want.reply_length, got.reply_length);
                check_field("tdata pad", '0, 64'(d >> PAYLOAD_W));
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
